@@ rtl/core/bpm_pkg.sv @@
// ----------------------------------------------------------------------------
// bpm_pkg
// Shared types, bracket tables and symbol decoding for the bracket pair matcher.
// ----------------------------------------------------------------------------
package bpm_pkg;

   localparam int unsigned ALL_TYPES = 27;
   localparam int unsigned TYPE_W    = 5;
   localparam int unsigned SYM_W     = 8;
   localparam int unsigned OUT_POS_W = 10;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_ILLEGAL   = 3'd1,
      ST_UNMATCHED = 3'd2,
      ST_UNCLOSED  = 3'd3,
      ST_TOOLONG   = 3'd4
   } status_type;

   // Opening and closing characters, in type order.
   localparam logic [SYM_W-1:0] OPENER_TAB [ALL_TYPES] = '{
      8'h28, 8'h5B, 8'h7B, 8'h3C, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46,
      8'h47, 8'h48, 8'h49, 8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50,
      8'h51, 8'h52, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A
   };
   localparam logic [SYM_W-1:0] CLOSER_TAB [ALL_TYPES] = '{
      8'h29, 8'h5D, 8'h7D, 8'h3E, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66,
      8'h67, 8'h68, 8'h69, 8'h6A, 8'h6B, 8'h6C, 8'h6D, 8'h6E, 8'h6F, 8'h70,
      8'h71, 8'h72, 8'h76, 8'h77, 8'h78, 8'h79, 8'h7A
   };

   typedef struct packed {
      logic              is_open;
      logic              is_close;
      logic [TYPE_W-1:0] kind;
   } sym_class_type;

   // Result beat payload, lowest field at the bottom.
   typedef struct packed {
      logic [2:0]           pad;
      status_type           status;
      logic [TYPE_W-1:0]    bracket_kind;
      logic [OUT_POS_W-1:0] close_pos;
      logic [OUT_POS_W-1:0] open_pos;
      logic                 pair_found;
   } rsp_payload_type;

   function automatic sym_class_type classify(logic [SYM_W-1:0] sym,
                                              int unsigned num_types);
      sym_class_type r;
      r = '0;
      for (int t = ALL_TYPES - 1; t >= 0; t--) begin
         if (t < num_types) begin
            if (sym == OPENER_TAB[t]) begin
               r.is_open  = 1'b1;
               r.is_close = 1'b0;
               r.kind     = TYPE_W'(t);
            end
            if (sym == CLOSER_TAB[t]) begin
               r.is_open  = 1'b0;
               r.is_close = 1'b1;
               r.kind     = TYPE_W'(t);
            end
         end
      end
      return r;
   endfunction

   // Spacer symbols; 'x' only reaches here when it is not a bracket.
   function automatic logic is_spacer(logic [SYM_W-1:0] sym);
      return (sym == 8'h2E) || (sym == 8'h2C) || (sym == 8'h78) || (sym == 8'h2D) ||
             (sym == 8'h7E) || (sym == 8'h3F) || (sym == 8'h5F);
   endfunction

endpackage

@@ rtl/core/bpm_link_ram.sv @@
// ----------------------------------------------------------------------------
// bpm_link_ram
// Position-indexed link memory: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bpm_link_ram #(
   parameter int unsigned DEPTH  = 1024,
   parameter int unsigned ADDR_W = 10,
   parameter int unsigned DATA_W = 11
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/multi_bracket_pair_matcher_unit.sv @@
// ----------------------------------------------------------------------------
// multi_bracket_pair_matcher_unit
// Streams a dot-bracket structure and reports base pairs and line errors.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  carries one structure character per beat (tdata = ASCII code),
//          req_tlast flags the last character of a line.
//   rsp_*  returns exactly one result beat per request beat, in order.
//          rsp_tlast echoes the request's line end.
// Timing: a taken beat sits in the input register and its result is
//   loaded into the output register at the next edge where that register is
//   free or being drained. One beat per cycle is sustained while rsp_tready
//   stays high: each character does at most one push or one pop, touching
//   one stack top register and one port of the link memory.
// Stacks: every bracket type keeps its top and second entry in registers;
//   deeper entries live in the link memory. A pop fetches the new second
//   entry from memory, and that value is folded into the registers on the
//   following cycle, so back-to-back pops of one type never wait.
// Reset clears the position, stack tops and the failed flag; the link memory
//   needs no clearing. When rsp_tready is low, the output register holds and
//   the input register keeps at most one more beat before req_tready drops.
// ----------------------------------------------------------------------------
module multi_bracket_pair_matcher_unit #(
   parameter int unsigned MAX_LEN   = 1024,
   parameter int unsigned NUM_TYPES = 27
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] symbol
   input  logic        req_tlast,   // line_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [0] pair_found, [10:1] open_pos, [20:11] close_pos,
                                    // [25:21] bracket_kind, [28:26] status, [31:29] zero
   output logic        rsp_tlast    // line_done
);

   localparam int unsigned POS_W  = $clog2(MAX_LEN + 1);
   localparam int unsigned ADDR_W = $clog2(MAX_LEN);
   localparam int unsigned TW     = bpm_pkg::TYPE_W;
   localparam int unsigned OW     = bpm_pkg::OUT_POS_W;
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_LEN);
   localparam logic [POS_W-1:0] POS_ONE   = POS_W'(1);

   // Input register
   logic                      in_vld_ff;
   logic [bpm_pkg::SYM_W-1:0] in_sym_ff;
   logic                      in_last_ff;

   // Output register
   logic                     rsp_vld_ff;
   bpm_pkg::rsp_payload_type rsp_data_ff;
   bpm_pkg::rsp_payload_type rsp_data_in;
   logic                     rsp_last_ff;

   // Line state
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             failed_ff, failed_in;
   logic [POS_W-1:0] top_ff [NUM_TYPES];
   logic [POS_W-1:0] top_in [NUM_TYPES];
   logic [POS_W-1:0] nxt_ff [NUM_TYPES];
   logic [POS_W-1:0] nxt_in [NUM_TYPES];
   logic [POS_W-1:0] nxt_eff [NUM_TYPES];
   logic             pend_ff, pend_in;
   logic [TW-1:0]    pend_ty_ff, pend_ty_in;

   // Link memory port signals
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [POS_W-1:0]  wr_data, rd_data;

   logic                  adv;
   bpm_pkg::sym_class_type cls;
   logic [POS_W-1:0]      sel_top, sel_nxt;
   logic [POS_W+OW-1:0]   opos_wide, cpos_wide;
   bpm_pkg::status_type   status;
   logic                  found;
   logic [TW-1:0]         kind;
   logic                  any_open;
   logic [TW-1:0]         low_open;

   // Advance the work stage when it holds a beat and the output can take it.
   assign adv        = in_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_sym_ff  <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // Fold a pending link read into the second-entry view of its type.
   always_comb begin
      for (int t = 0; t < NUM_TYPES; t++) begin
         if (pend_ff && (pend_ty_ff == TW'(t))) begin
            nxt_eff[t] = rd_data;
         end else begin
            nxt_eff[t] = nxt_ff[t];
         end
      end
   end

   assign cls = bpm_pkg::classify(in_sym_ff, NUM_TYPES);

   always_comb begin
      sel_top = '0;
      sel_nxt = '0;
      for (int t = 0; t < NUM_TYPES; t++) begin
         if (cls.kind == TW'(t)) begin
            sel_top = top_ff[t];
            sel_nxt = nxt_eff[t];
         end
      end
   end

   // Character processing: one push, one pop or nothing.
   always_comb begin
      status     = bpm_pkg::ST_OK;
      found      = 1'b0;
      kind       = '0;
      pos_in     = pos_ff;
      failed_in  = failed_ff;
      pend_in    = 1'b0;
      pend_ty_in = cls.kind;
      wr_en      = 1'b0;
      rd_en      = 1'b0;
      wr_addr    = ADDR_W'(pos_ff);
      wr_data    = sel_top;
      rd_addr    = ADDR_W'(sel_nxt - POS_ONE);
      opos_wide  = {{OW{1'b0}}, sel_top - POS_ONE};
      cpos_wide  = {{OW{1'b0}}, pos_ff};
      any_open   = 1'b0;
      low_open   = '0;
      for (int t = 0; t < NUM_TYPES; t++) begin
         top_in[t] = top_ff[t];
         nxt_in[t] = nxt_eff[t];
      end

      if (!failed_ff) begin
         if (pos_ff >= POS_LIMIT) begin
            status = bpm_pkg::ST_TOOLONG;
         end else begin
            if (cls.is_open) begin
               // Push: old top slides to second and is stored in memory as the new entry's link.
               wr_en = adv;
               for (int t = 0; t < NUM_TYPES; t++) begin
                  if (cls.kind == TW'(t)) begin
                     top_in[t] = pos_ff + POS_ONE;
                     nxt_in[t] = top_ff[t];
                  end
               end
            end else if (cls.is_close) begin
               kind = cls.kind;
               if (sel_top == '0) begin
                  status = bpm_pkg::ST_UNMATCHED;
               end else begin
                  // Pop: second becomes top, fetch the entry below it.
                  found = 1'b1;
                  if (sel_nxt != '0) begin
                     rd_en   = adv;
                     pend_in = 1'b1;
                  end
                  for (int t = 0; t < NUM_TYPES; t++) begin
                     if (cls.kind == TW'(t)) begin
                        top_in[t] = sel_nxt;
                        nxt_in[t] = '0;
                     end
                  end
               end
            end else if (!bpm_pkg::is_spacer(in_sym_ff)) begin
               status = bpm_pkg::ST_ILLEGAL;
            end
            pos_in = pos_ff + POS_ONE;
         end

         if ((status == bpm_pkg::ST_OK) && in_last_ff) begin
            for (int t = NUM_TYPES - 1; t >= 0; t--) begin
               if (top_in[t] != '0) begin
                  any_open = 1'b1;
                  low_open = TW'(t);
               end
            end
            if (any_open) begin
               status = bpm_pkg::ST_UNCLOSED;
               kind   = low_open;
            end
         end

         if (status != bpm_pkg::ST_OK) begin
            found     = 1'b0;
            failed_in = 1'b1;
            if ((status != bpm_pkg::ST_UNMATCHED) && (status != bpm_pkg::ST_UNCLOSED)) begin
               kind = '0;
            end
         end
      end

      // Drop all line state after the last character.
      if (in_last_ff) begin
         pos_in    = '0;
         failed_in = 1'b0;
         pend_in   = 1'b0;
         for (int t = 0; t < NUM_TYPES; t++) begin
            top_in[t] = '0;
            nxt_in[t] = '0;
         end
      end

      rsp_data_in              = '0;
      rsp_data_in.status       = status;
      rsp_data_in.bracket_kind = kind;
      rsp_data_in.pair_found   = found;
      if (found) begin
         rsp_data_in.open_pos  = opos_wide[OW-1:0];
         rsp_data_in.close_pos = cpos_wide[OW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         failed_ff <= 1'b0;
         pend_ff   <= 1'b0;
         for (int t = 0; t < NUM_TYPES; t++) begin
            top_ff[t] <= '0;
            nxt_ff[t] <= '0;
         end
      end else if (adv) begin
         pos_ff    <= pos_in;
         failed_ff <= failed_in;
         pend_ff   <= pend_in;
         for (int t = 0; t < NUM_TYPES; t++) begin
            top_ff[t] <= top_in[t];
            nxt_ff[t] <= nxt_in[t];
         end
      end else begin
         // Commit a fetched link value even while stalled.
         pend_ff <= 1'b0;
         for (int t = 0; t < NUM_TYPES; t++) begin
            nxt_ff[t] <= nxt_eff[t];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pend_ty_ff <= pend_ty_in;
      end
   end

   bpm_link_ram #(
      .DEPTH  (MAX_LEN),
      .ADDR_W (ADDR_W),
      .DATA_W (POS_W)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Output register: load on advance, release on a taken beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= in_last_ff;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // A pending link read only follows a cycle in which the work stage advanced.
   a_pend_after_adv: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $past(adv))
      else $error("link read pending without a processed beat");

   // A reported pair always carries an ok status.
   a_pair_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_data_ff.pair_found) |-> (rsp_data_ff.status == bpm_pkg::ST_OK))
      else $error("pair reported together with an error");

   // Line state is cleared after the last character of a line.
   a_line_clear: assert property (@(posedge clock) disable iff (reset)
      (adv && in_last_ff) |=> ((pos_ff == '0) && !failed_ff && !pend_ff))
      else $error("line state not cleared at line end");

   // Position saturates at the line limit.
   a_pos_limit: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_LIMIT)
      else $error("position beyond line limit");

endmodule

@@ tb/tb_multi_bracket_pair_matcher_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_bracket_pair_matcher_unit
// Streams dot-bracket lines into the matcher and checks each result beat
// against an in-bench parser: pairs per bracket type, pseudoknots, skipped
// symbols and the line errors, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_multi_bracket_pair_matcher_unit;

   localparam int unsigned LINE_MAX   = 1024;
   localparam int unsigned KINDS      = 27;
   localparam int unsigned KIND_W     = bpm_pkg::TYPE_W;
   localparam int unsigned RES_POS_W  = bpm_pkg::OUT_POS_W;
   localparam int unsigned STALL_MAX  = 2000;   // cycles with no beat on either side
   localparam int unsigned QUIET_TAIL = 120;    // last beats sent with no idling

   // Bracket characters in type order, first character in the top byte.
   localparam logic [8*KINDS-1:0] OPEN_CHARS  = "([{<ABCDEFGHIJKLMNOPQRVWXYZ";
   localparam logic [8*KINDS-1:0] CLOSE_CHARS = ")]}>abcdefghijklmnopqrvwxyz";
   localparam logic [8*6-1:0]     DOT_CHARS   = ".,-~?_";

   typedef enum int {
      LINE_CLEAN, LINE_NOISE, LINE_UNCLOSED, LINE_UNMATCHED, LINE_GARBAGE
   } line_flavor_type;

   typedef struct packed {
      logic       lend;
      logic [7:0] sym;
   } char_beat_type;

   typedef struct packed {
      logic                   done;
      bpm_pkg::status_type    status;
      logic [KIND_W-1:0]      kind;
      logic [RES_POS_W-1:0]   cpos;
      logic [RES_POS_W-1:0]   opos;
      logic                   found;
   } pair_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;

   // Parser state mirrored in the bench.
   int unsigned line_pos;
   int unsigned top_plus1 [KINDS];
   int unsigned link_mem  [LINE_MAX];
   bit          line_dead;

   char_beat_type   char_queue [$];
   pair_result_type pending_results [$];

   int unsigned mismatches;
   int unsigned rsp_beats;
   int unsigned req_beats;
   int unsigned pairs_seen;
   int unsigned lines_seen;
   int unsigned errors_seen [5];
   int unsigned src_gap, snk_gap;
   int unsigned src_idle_pct = 5;
   int unsigned snk_idle_pct = 5;
   int unsigned idle_cycles;

   multi_bracket_pair_matcher_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [7:0] opener(int t);
      return OPEN_CHARS[8*(KINDS-1-t) +: 8];
   endfunction

   function automatic logic [7:0] closer(int t);
      return CLOSE_CHARS[8*(KINDS-1-t) +: 8];
   endfunction

   // +(type+1) for an opening bracket, -(type+1) for a closing one, else 0.
   function automatic int bracket_class(logic [7:0] sym);
      for (int t = 0; t < KINDS; t++) begin
         if (sym == opener(t)) return t + 1;
         if (sym == closer(t)) return -(t + 1);
      end
      return 0;
   endfunction

   function automatic bit is_dot(logic [7:0] sym);
      return sym == "." || sym == "," || sym == "x" || sym == "-" ||
             sym == "~" || sym == "?" || sym == "_";
   endfunction

   // Advance the mirrored parser by one character and return the result beat.
   function automatic pair_result_type parse_symbol(logic [7:0] sym, logic lend);
      pair_result_type r;
      int              cls;
      int unsigned     ty;
      r        = '0;
      r.status = bpm_pkg::ST_OK;
      r.done   = lend;
      if (!line_dead) begin
         if (line_pos >= LINE_MAX) begin
            r.status = bpm_pkg::ST_TOOLONG;
         end else begin
            cls = bracket_class(sym);
            if (cls > 0) begin
               ty                 = cls - 1;
               link_mem[line_pos] = top_plus1[ty];
               top_plus1[ty]      = line_pos + 1;
            end else if (cls < 0) begin
               ty     = -cls - 1;
               r.kind = KIND_W'(ty);
               if (top_plus1[ty] == 0) begin
                  r.status = bpm_pkg::ST_UNMATCHED;
               end else begin
                  r.found       = 1'b1;
                  r.opos        = RES_POS_W'(top_plus1[ty] - 1);
                  r.cpos        = RES_POS_W'(line_pos);
                  top_plus1[ty] = link_mem[top_plus1[ty] - 1];
               end
            end else if (!is_dot(sym)) begin
               r.status = bpm_pkg::ST_ILLEGAL;
            end
            line_pos++;
         end
         // Lowest type still open at line end wins.
         if (r.status == bpm_pkg::ST_OK && lend) begin
            for (int t = 0; t < KINDS; t++) begin
               if (top_plus1[t] != 0) begin
                  r.status = bpm_pkg::ST_UNCLOSED;
                  r.kind   = KIND_W'(t);
                  break;
               end
            end
         end
         if (r.status != bpm_pkg::ST_OK) begin
            r.found = 1'b0;
            r.opos  = '0;
            r.cpos  = '0;
            if (r.status != bpm_pkg::ST_UNMATCHED && r.status != bpm_pkg::ST_UNCLOSED)
               r.kind = '0;
            line_dead = 1'b1;
         end
      end
      if (lend) begin
         line_pos  = 0;
         line_dead = 1'b0;
         foreach (top_plus1[t]) top_plus1[t] = 0;
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH result %0d: %s got %0d want %0d", rsp_beats, what, got, want);
      mismatches++;
   endtask

   task automatic add_char(logic [7:0] sym, logic lend);
      char_beat_type beat;
      beat.lend = lend;
      beat.sym  = sym;
      char_queue.insert(char_queue.size(), beat);
   endtask

   task automatic add_text(string txt);
      for (int i = 0; i < txt.len(); i++) add_char(txt[i], i == txt.len() - 1);
   endtask

   // Build one line. The first LINE_MAX characters follow the flavor; the
   // rest are random bytes, and the first reports too long unless the line failed.
   task automatic add_line(int unsigned len, line_flavor_type flavor);
      logic [7:0]  body [$];
      int unsigned open_cnt [KINDS];
      int unsigned open_total, remaining, core_len, bad_at, r, t;
      core_len = (len > LINE_MAX) ? LINE_MAX : len;
      bad_at   = $urandom_range(0, core_len - 1);
      open_total = 0;
      foreach (open_cnt[k]) open_cnt[k] = 0;
      for (int unsigned i = 0; i < core_len; i++) begin
         remaining = core_len - i;
         r         = $urandom_range(0, 99);
         if (flavor == LINE_GARBAGE) begin
            body.insert(body.size(), 8'($urandom_range(0, 255)));
         end else if (flavor == LINE_UNMATCHED && i == bad_at) begin
            // Close a type that has nothing open, or put a dot if every type is open.
            t = $urandom_range(0, KINDS - 1);
            for (int k = 0; k < KINDS && open_cnt[t] != 0; k++) t = (t + 1) % KINDS;
            body.insert(body.size(), open_cnt[t] == 0 ? closer(t) : 8'h2E);
         end else if (open_total > 0 &&
                      ((flavor != LINE_UNCLOSED && open_total >= remaining) || r < 35)) begin
            t = $urandom_range(0, KINDS - 1);
            while (open_cnt[t] == 0) t = (t + 1) % KINDS;
            open_cnt[t]--;
            open_total--;
            body.insert(body.size(), closer(t));
         end else if (r < 75 && (flavor == LINE_UNCLOSED || open_total + 1 < remaining)) begin
            // Favor a few types so stacks grow deep.
            t = ($urandom_range(0, 99) < 60) ? $urandom_range(0, 3)
                                             : $urandom_range(0, KINDS - 1);
            open_cnt[t]++;
            open_total++;
            body.insert(body.size(), opener(t));
         end else begin
            body.insert(body.size(), DOT_CHARS[8*$urandom_range(0, 5) +: 8]);
         end
      end
      if (flavor == LINE_NOISE) body[bad_at] = 8'($urandom_range(0, 255));
      for (int unsigned i = core_len; i < len; i++)
         body.insert(body.size(), 8'($urandom_range(0, 255)));
      foreach (body[i]) add_char(body[i], i == body.size() - 1);
   endtask

   // Source side: hand out pending characters, predict each accepted one.
   always @(posedge clock) begin : drive_proc
      char_beat_type beat;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            pending_results.insert(pending_results.size(),
                                   parse_symbol(req_tdata, req_tlast));
            req_beats++;
            if (req_beats % 97 == 0)
               src_idle_pct = ($urandom_range(0, 2) == 0) ? 0
                                                          : 4 + 12 * $urandom_range(0, 1);
         end
         if (!req_tvalid || req_tready) begin
            if (src_gap > 0) begin
               src_gap--;
               req_tvalid <= 1'b0;
            end else if (char_queue.size() >= QUIET_TAIL &&
                         $urandom_range(0, 99) < src_idle_pct) begin
               src_gap = $urandom_range(0, 14);
               req_tvalid <= 1'b0;
            end else if (char_queue.size() > 0) begin
               beat = char_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= beat.sym;
               req_tlast  <= beat.lend;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Sink side: check every result beat, then decide the next ready.
   always @(posedge clock) begin : watch_proc
      bpm_pkg::rsp_payload_type got;
      pair_result_type          want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (pending_results.size() == 0) begin
               report_mismatch("result with nothing pending, tdata", rsp_tdata, 0);
            end else begin
               want = pending_results.pop_front();
               if (got.pair_found !== want.found)
                  report_mismatch("pair_found", got.pair_found, want.found);
               if (got.open_pos !== want.opos)
                  report_mismatch("open_pos", got.open_pos, want.opos);
               if (got.close_pos !== want.cpos)
                  report_mismatch("close_pos", got.close_pos, want.cpos);
               if (got.bracket_kind !== want.kind)
                  report_mismatch("bracket_kind", got.bracket_kind, want.kind);
               if (got.status !== want.status)
                  report_mismatch("status", got.status, want.status);
               if (rsp_tlast !== want.done)
                  report_mismatch("line_done", rsp_tlast, want.done);
               pairs_seen += want.found;
               lines_seen += want.done;
               if (want.status != bpm_pkg::ST_OK) errors_seen[want.status]++;
            end
            rsp_beats++;
            if (rsp_beats % 101 == 0)
               snk_idle_pct = ($urandom_range(0, 2) == 0) ? 0
                                                          : 4 + 12 * $urandom_range(0, 1);
         end
         if (snk_gap > 0) begin
            snk_gap--;
            rsp_tready <= 1'b0;
         end else if (char_queue.size() >= QUIET_TAIL &&
                      $urandom_range(0, 99) < snk_idle_pct) begin
            snk_gap = $urandom_range(0, 14);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Drop the run if neither channel moves for too long.
   always @(posedge clock) begin : watchdog_proc
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_MAX) begin
            $display("Timeout: no beat for %0d cycles, %0d results pending",
                     STALL_MAX, pending_results.size());
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin : stimulus_proc
      int unsigned     short_chars;
      int unsigned     r;
      line_flavor_type flavor;
      line_pos  = 0;
      line_dead = 1'b0;
      foreach (top_plus1[t]) top_plus1[t] = 0;
      foreach (errors_seen[i]) errors_seen[i] = 0;

      // Directed lines: skipped symbols inside a pair, x as a closer,
      // unmatched close then a dead line, illegal byte, pair on the line end
      // with another type still open, an opener on the line end, nesting.
      add_text("(.,-~?_)");
      add_text("Xx");
      add_text("x..");
      add_char("(", 1'b0);
      add_char(8'hFF, 1'b0);
      add_char(")", 1'b1);
      add_text("A()");
      add_text("<");
      add_text("[{<>}]");

      // Random lines, mostly well formed.
      short_chars = 0;
      while (short_chars < 920) begin
         r = $urandom_range(0, 99);
         flavor = (r < 66) ? LINE_CLEAN     :
                  (r < 76) ? LINE_NOISE     :
                  (r < 86) ? LINE_UNCLOSED  :
                  (r < 94) ? LINE_UNMATCHED : LINE_GARBAGE;
         r = (flavor == LINE_GARBAGE) ? $urandom_range(1, 8) : $urandom_range(1, 40);
         add_line(r, flavor);
         short_chars += r;
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (char_queue.size() > 0 || req_tvalid) @(posedge clock);
      while (pending_results.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Covered %0d characters in %0d lines: %0d pairs closed", rsp_beats,
               lines_seen, pairs_seen);
      $display("Errors seen: illegal %0d, unmatched %0d, unclosed %0d, too long %0d",
               errors_seen[bpm_pkg::ST_ILLEGAL], errors_seen[bpm_pkg::ST_UNMATCHED],
               errors_seen[bpm_pkg::ST_UNCLOSED], errors_seen[bpm_pkg::ST_TOOLONG]);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/bpm_pkg.sv
rtl/core/bpm_link_ram.sv
rtl/core/multi_bracket_pair_matcher_unit.sv
tb/tb_multi_bracket_pair_matcher_unit.sv
